### rtl/core/cftd_pkg.sv
package cftd_pkg;

	localparam int ID_W       = 11;
	localparam int CNT_W      = 4;
	localparam int PAYLOAD_W  = 64;
	localparam int TICK_W     = 32;
	localparam int WORD_IDX_W = 4;
	localparam int DATA_W     = 64;
	localparam int SEQ_W      = 16;
	localparam int PERIOD_W   = 6;
	localparam int DROP_W     = 16;
	localparam int BYTES_W    = 96;
	localparam int SSM_REC_W  = 53;
	localparam int PSM_REC_W  = 60;
	localparam int ADC_W      = 10;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam int SSM_IDS    = 8;
	localparam int PSM_IDS    = 2;
	localparam int COPY_BYTES = 6;
	localparam int MAX_GROUPS = 4;
	localparam int PSM_ADCS   = 4;

	localparam int SSM_ALIVE_BIT = 52;
	localparam int PSM_ALIVE_BIT = 59;
	localparam int SSM_CUR_LSB   = 12;

	localparam logic [CNT_W-1:0] LEN_MAX        = 4'd8;
	localparam logic [CNT_W-1:0] LEN_COPY       = 4'd4;
	localparam logic [CNT_W-1:0] LEN_FLASH_HIGH = 4'd5;
	localparam logic [CNT_W-1:0] LEN_PERIOD     = 4'd6;
	localparam logic [CNT_W-1:0] LEN_SSM        = 4'd7;
	localparam logic [CNT_W-1:0] LEN_PSM        = 4'd8;

	localparam logic [DROP_W-1:0] DROP_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_FRAME  = 2'd0,
		OP_COMMIT = 2'd1,
		OP_READ   = 2'd2
	} op_e;

	typedef enum logic [2:0] {
		REG_SWITCH_LOW  = 3'd0,
		REG_SWITCH_HIGH = 3'd1,
		REG_FLASH_LOW   = 3'd2,
		REG_FLASH_HIGH  = 3'd3,
		REG_SSM_BASE    = 3'd4,
		REG_PSM_BASE    = 3'd5,
		REG_DROP_COUNT  = 3'd6
	} reg_idx_e;

	typedef enum logic [2:0] {
		KIND_SWITCH_LOW,
		KIND_SWITCH_HIGH,
		KIND_FLASH_LOW,
		KIND_FLASH_HIGH,
		KIND_SSM,
		KIND_PSM,
		KIND_UNKNOWN
	} frame_kind_e;

	typedef struct packed {
		logic [ID_W-1:0] switch_low_id;
		logic [ID_W-1:0] switch_high_id;
		logic [ID_W-1:0] flash_low_id;
		logic [ID_W-1:0] flash_high_id;
		logic [ID_W-1:0] ssm_base_id;
		logic [ID_W-1:0] psm_base_id;
	} cfg_ids_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] flash_period;
		logic                cpu_alive;
		logic [SEQ_W-1:0]    sequence_num;
	} live_hdr_t;

	typedef struct packed {
		logic frame_en;
		logic commit_en;
	} live_ctrl_t;

endpackage

### rtl/core/cftd_cfg_regs.sv
module cftd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cftd_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [cftd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [cftd_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	input  logic [cftd_pkg::DROP_W-1:0]       drop_count,
	output cftd_pkg::cfg_ids_t                cfg_ids
);
	import cftd_pkg::*;

	cfg_ids_t cfg_q;
	reg_idx_e reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_e'(paddr[4:2]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg_ids = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SWITCH_LOW:  cfg_q.switch_low_id  <= pwdata[ID_W-1:0];
				REG_SWITCH_HIGH: cfg_q.switch_high_id <= pwdata[ID_W-1:0];
				REG_FLASH_LOW:   cfg_q.flash_low_id   <= pwdata[ID_W-1:0];
				REG_FLASH_HIGH:  cfg_q.flash_high_id  <= pwdata[ID_W-1:0];
				REG_SSM_BASE:    cfg_q.ssm_base_id    <= pwdata[ID_W-1:0];
				REG_PSM_BASE:    cfg_q.psm_base_id    <= pwdata[ID_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_SWITCH_LOW:  prdata = APB_DATA_W'(cfg_q.switch_low_id);
			REG_SWITCH_HIGH: prdata = APB_DATA_W'(cfg_q.switch_high_id);
			REG_FLASH_LOW:   prdata = APB_DATA_W'(cfg_q.flash_low_id);
			REG_FLASH_HIGH:  prdata = APB_DATA_W'(cfg_q.flash_high_id);
			REG_SSM_BASE:    prdata = APB_DATA_W'(cfg_q.ssm_base_id);
			REG_PSM_BASE:    prdata = APB_DATA_W'(cfg_q.psm_base_id);
			REG_DROP_COUNT:  prdata = APB_DATA_W'(drop_count);
			default:         prdata = '0;
		endcase
	end

endmodule

### rtl/core/cftd_live_image.sv
module cftd_live_image #(
	parameter int SSM_MODULES    = 8,
	parameter int PSM_MODULES    = 2,
	parameter int CURRENT_GROUPS = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cftd_pkg::live_ctrl_t               ctrl,
	input  cftd_pkg::cfg_ids_t                 cfg_ids,
	input  logic [cftd_pkg::ID_W-1:0]          frame_id,
	input  logic [cftd_pkg::CNT_W-1:0]         byte_count,
	input  logic [cftd_pkg::PAYLOAD_W-1:0]     payload,
	output cftd_pkg::live_hdr_t                hdr,
	output logic [cftd_pkg::BYTES_W-1:0]       switch_bytes,
	output logic [cftd_pkg::BYTES_W-1:0]       flash_bytes,
	output logic [cftd_pkg::SSM_REC_W-1:0]     ssm_rec [SSM_MODULES],
	output logic [cftd_pkg::PSM_REC_W-1:0]     psm_rec [PSM_MODULES],
	output logic [cftd_pkg::DROP_W-1:0]        drop_count
);
	import cftd_pkg::*;

	live_hdr_t              hdr_q;
	logic [BYTES_W-1:0]     switch_q;
	logic [BYTES_W-1:0]     flash_q;
	logic [SSM_REC_W-1:0]   ssm_q [SSM_MODULES];
	logic [PSM_REC_W-1:0]   psm_q [PSM_MODULES];
	logic [DROP_W-1:0]      drop_q;

	logic [CNT_W-1:0]       len;
	logic [ID_W:0]          ssm_diff;
	logic [ID_W:0]          psm_diff;
	logic                   ssm_range;
	logic                   psm_range;
	frame_kind_e            kind;
	logic [ADC_W-1:0]       cur [MAX_GROUPS];
	logic [PSM_REC_W-1:0]   psm_new;

	always_comb begin
		len       = (byte_count > LEN_MAX) ? LEN_MAX : byte_count;
		ssm_diff  = {1'b0, frame_id} - {1'b0, cfg_ids.ssm_base_id};
		psm_diff  = {1'b0, frame_id} - {1'b0, cfg_ids.psm_base_id};
		ssm_range = (frame_id >= cfg_ids.ssm_base_id) && (ssm_diff < (ID_W+1)'(SSM_IDS));
		psm_range = (frame_id >= cfg_ids.psm_base_id) && (psm_diff < (ID_W+1)'(PSM_IDS));
		priority if (frame_id == cfg_ids.switch_low_id)  kind = KIND_SWITCH_LOW;
		else if (frame_id == cfg_ids.switch_high_id)     kind = KIND_SWITCH_HIGH;
		else if (frame_id == cfg_ids.flash_low_id)       kind = KIND_FLASH_LOW;
		else if (frame_id == cfg_ids.flash_high_id)      kind = KIND_FLASH_HIGH;
		else if (ssm_range)                              kind = KIND_SSM;
		else if (psm_range)                              kind = KIND_PSM;
		else                                             kind = KIND_UNKNOWN;
	end

	always_comb begin
		for (int g = 0; g < MAX_GROUPS; g++) begin
			cur[g] = {payload[48 + 2*g +: 2], payload[16 + 8*g +: 8]};
		end
		psm_new = '0;
		for (int a = 0; a < PSM_ADCS; a++) begin
			psm_new[ADC_W*a +: ADC_W] = {payload[40 + 2*a +: 2], payload[8*a +: 8]};
		end
		psm_new[49:40]         = {payload[49:48], payload[39:32]};
		psm_new[50]            = payload[50];
		psm_new[58:51]         = payload[63:56];
		psm_new[PSM_ALIVE_BIT] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= '0;
			switch_q <= '0;
			flash_q  <= '0;
			for (int e = 0; e < SSM_MODULES; e++) begin
				ssm_q[e] <= '0;
			end
			for (int e = 0; e < PSM_MODULES; e++) begin
				psm_q[e] <= '0;
			end
		end else if (ctrl.frame_en) begin
			unique case (kind)
				KIND_SWITCH_LOW: begin
					if (len >= LEN_COPY) begin
						for (int i = 0; i < COPY_BYTES; i++) begin
							if (CNT_W'(i) < len) switch_q[8*i +: 8] <= payload[8*i +: 8];
						end
					end
				end
				KIND_SWITCH_HIGH: begin
					if (len >= LEN_COPY) begin
						for (int i = 0; i < COPY_BYTES; i++) begin
							if (CNT_W'(i) < len) switch_q[48 + 8*i +: 8] <= payload[8*i +: 8];
						end
						hdr_q.sequence_num <= hdr_q.sequence_num + 1'b1;
						hdr_q.cpu_alive    <= 1'b1;
					end
				end
				KIND_FLASH_LOW: begin
					if (len >= LEN_COPY) begin
						for (int i = 0; i < COPY_BYTES; i++) begin
							if (CNT_W'(i) < len) flash_q[8*i +: 8] <= payload[8*i +: 8];
						end
					end
				end
				KIND_FLASH_HIGH: begin
					if (len >= LEN_FLASH_HIGH) begin
						for (int i = 0; i < COPY_BYTES; i++) begin
							if (CNT_W'(i) < len) flash_q[48 + 8*i +: 8] <= payload[8*i +: 8];
						end
						if (len >= LEN_PERIOD) hdr_q.flash_period <= payload[45:40];
					end
				end
				KIND_SSM: begin
					if (len >= LEN_SSM) begin
						for (int e = 0; e < SSM_MODULES; e++) begin
							if (ssm_diff[2:0] == 3'(e)) begin
								ssm_q[e][11:0] <= {payload[11:8], payload[7:0]};
								for (int g = 0; g < CURRENT_GROUPS; g++) begin
									ssm_q[e][SSM_CUR_LSB + ADC_W*g +: ADC_W] <= cur[g];
								end
								ssm_q[e][SSM_ALIVE_BIT] <= 1'b1;
							end
						end
					end
				end
				KIND_PSM: begin
					if (len >= LEN_PSM) begin
						for (int e = 0; e < PSM_MODULES; e++) begin
							if (psm_diff[0] == 1'(e)) psm_q[e] <= psm_new;
						end
					end
				end
				default: ;
			endcase
		end else if (ctrl.commit_en) begin
			hdr_q.cpu_alive <= 1'b0;
			for (int e = 0; e < SSM_MODULES; e++) begin
				ssm_q[e][SSM_ALIVE_BIT] <= 1'b0;
			end
			for (int e = 0; e < PSM_MODULES; e++) begin
				psm_q[e][PSM_ALIVE_BIT] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= '0;
		end else if (ctrl.frame_en && kind == KIND_UNKNOWN && drop_q != DROP_MAX) begin
			drop_q <= drop_q + 1'b1;
		end
	end

	assign hdr          = hdr_q;
	assign switch_bytes = switch_q;
	assign flash_bytes  = flash_q;
	assign ssm_rec      = ssm_q;
	assign psm_rec      = psm_q;
	assign drop_count   = drop_q;

endmodule

### rtl/core/cftd_commit_image.sv
module cftd_commit_image #(
	parameter int SSM_MODULES = 8,
	parameter int PSM_MODULES = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               commit_en,
	input  logic [cftd_pkg::TICK_W-1:0]        tick_count,
	input  cftd_pkg::live_hdr_t                hdr,
	input  logic [cftd_pkg::BYTES_W-1:0]       switch_bytes,
	input  logic [cftd_pkg::BYTES_W-1:0]       flash_bytes,
	input  logic [cftd_pkg::SSM_REC_W-1:0]     ssm_rec [SSM_MODULES],
	input  logic [cftd_pkg::PSM_REC_W-1:0]     psm_rec [PSM_MODULES],
	input  logic [cftd_pkg::WORD_IDX_W-1:0]    read_word,
	output logic [cftd_pkg::DATA_W-1:0]        word
);
	import cftd_pkg::*;

	logic [TICK_W-1:0]     tick_q;
	live_hdr_t             hdr_q;
	logic [BYTES_W-1:0]    switch_q;
	logic [BYTES_W-1:0]    flash_q;
	logic [SSM_REC_W-1:0]  ssm_q [SSM_MODULES];
	logic [PSM_REC_W-1:0]  psm_q [PSM_MODULES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			hdr_q    <= '0;
			switch_q <= '0;
			flash_q  <= '0;
			for (int e = 0; e < SSM_MODULES; e++) begin
				ssm_q[e] <= '0;
			end
			for (int e = 0; e < PSM_MODULES; e++) begin
				psm_q[e] <= '0;
			end
		end else if (commit_en) begin
			tick_q   <= tick_count;
			hdr_q    <= hdr;
			switch_q <= switch_bytes;
			flash_q  <= flash_bytes;
			ssm_q    <= ssm_rec;
			psm_q    <= psm_rec;
		end
	end

	always_comb begin
		word = '0;
		if (read_word == 4'd0) word = {9'd0, hdr_q, tick_q};
		if (read_word == 4'd1) word = switch_q[63:0];
		if (read_word == 4'd2) word = {flash_q[95:64], switch_q[95:64]};
		if (read_word == 4'd3) word = flash_q[63:0];
		for (int e = 0; e < SSM_MODULES; e++) begin
			if (read_word == WORD_IDX_W'(4 + e)) word = DATA_W'(ssm_q[e]);
		end
		for (int e = 0; e < PSM_MODULES; e++) begin
			if (read_word == WORD_IDX_W'(12 + e)) word = DATA_W'(psm_q[e]);
		end
	end

endmodule

### rtl/core/can_frame_telemetry_decoder.sv
// CAN frame telemetry decoder.
// Item channel (item_valid / item_stall): op selects a received frame, a
// commit of the live image, or a read of one committed 64-bit word. Frames
// with extended identifiers are ignored; standard identifiers are matched
// against the six APB identifier registers and update the live image.
// Result channel (result_valid / result_stall): one transfer per read,
// carrying read_data; frames and commits produce no transfer.
// A read item goes from its transfer on the item channel into the input
// register, then into the result register.
// Throughput: one item per cycle while item_stall is low; the decode from
// the input register to the live/committed image registers is combinational.
// A stalled result holds its word; a read in the input register then
// waits and item_stall rises, while frames and commits keep flowing.
// Reset clears the identifier registers, the live and committed images and
// the drop count to zero. The drop count reads back at APB offset 0x18.
module can_frame_telemetry_decoder #(
	parameter int SSM_MODULES    = 8,
	parameter int PSM_MODULES    = 2,
	parameter int CURRENT_GROUPS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cftd_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [cftd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [cftd_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [1:0]                        op,
	input  logic                              standard_id,
	input  logic [cftd_pkg::ID_W-1:0]         frame_id,
	input  logic [cftd_pkg::CNT_W-1:0]        byte_count,
	input  logic [cftd_pkg::PAYLOAD_W-1:0]    payload,
	input  logic [cftd_pkg::TICK_W-1:0]       tick_count,
	input  logic [cftd_pkg::WORD_IDX_W-1:0]   read_word,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [cftd_pkg::DATA_W-1:0]       read_data
);
	import cftd_pkg::*;

	logic                    vld_s1;
	op_e                     op_s1;
	logic                    std_s1;
	logic [ID_W-1:0]         id_s1;
	logic [CNT_W-1:0]        cnt_s1;
	logic [PAYLOAD_W-1:0]    payload_s1;
	logic [TICK_W-1:0]       tick_s1;
	logic [WORD_IDX_W-1:0]   word_s1;

	logic                    res_valid_q;
	logic [DATA_W-1:0]       res_data_q;

	logic                    blocked;
	logic                    fire;
	logic                    read_en;
	live_ctrl_t              ctrl;
	cfg_ids_t                cfg_ids;
	logic [DROP_W-1:0]       drop_count;
	live_hdr_t               hdr;
	logic [BYTES_W-1:0]      switch_bytes;
	logic [BYTES_W-1:0]      flash_bytes;
	logic [SSM_REC_W-1:0]    ssm_rec [SSM_MODULES];
	logic [PSM_REC_W-1:0]    psm_rec [PSM_MODULES];
	logic [DATA_W-1:0]       word;

	assign blocked        = vld_s1 && op_s1 == OP_READ && res_valid_q && result_stall;
	assign fire           = vld_s1 && !blocked;
	assign item_stall     = blocked;
	assign ctrl.frame_en  = fire && op_s1 == OP_FRAME && std_s1;
	assign ctrl.commit_en = fire && op_s1 == OP_COMMIT;
	assign read_en        = fire && op_s1 == OP_READ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			op_s1      <= op_e'(op);
			std_s1     <= standard_id;
			id_s1      <= frame_id;
			cnt_s1     <= byte_count;
			payload_s1 <= payload;
			tick_s1    <= tick_count;
			word_s1    <= read_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (read_en) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (read_en) begin
			res_data_q <= word;
		end
	end

	assign result_valid = res_valid_q;
	assign read_data    = res_data_q;

	cftd_cfg_regs u_cfg_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.drop_count (drop_count),
		.cfg_ids    (cfg_ids)
	);

	cftd_live_image #(
		.SSM_MODULES    (SSM_MODULES),
		.PSM_MODULES    (PSM_MODULES),
		.CURRENT_GROUPS (CURRENT_GROUPS)
	) u_live_image (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.cfg_ids      (cfg_ids),
		.frame_id     (id_s1),
		.byte_count   (cnt_s1),
		.payload      (payload_s1),
		.hdr          (hdr),
		.switch_bytes (switch_bytes),
		.flash_bytes  (flash_bytes),
		.ssm_rec      (ssm_rec),
		.psm_rec      (psm_rec),
		.drop_count   (drop_count)
	);

	cftd_commit_image #(
		.SSM_MODULES (SSM_MODULES),
		.PSM_MODULES (PSM_MODULES)
	) u_commit_image (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit_en    (ctrl.commit_en),
		.tick_count   (tick_s1),
		.hdr          (hdr),
		.switch_bytes (switch_bytes),
		.flash_bytes  (flash_bytes),
		.ssm_rec      (ssm_rec),
		.psm_rec      (psm_rec),
		.read_word    (word_s1),
		.word         (word)
	);

endmodule

### tb/can_frame_telemetry_decoder_checker.sv
`timescale 1ns / 100ps

module can_frame_telemetry_decoder_checker #(
	parameter int SSM_MODULES    = 8,
	parameter int PSM_MODULES    = 2,
	parameter int CURRENT_GROUPS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cftd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cftd_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [cftd_pkg::APB_DATA_W-1:0] prdata,
	input  logic                            pready,
	input  logic                            item_valid,
	input  logic                            item_stall,
	input  logic [1:0]                      op,
	input  logic                            standard_id,
	input  logic [cftd_pkg::ID_W-1:0]       frame_id,
	input  logic [cftd_pkg::CNT_W-1:0]      byte_count,
	input  logic [cftd_pkg::PAYLOAD_W-1:0]  payload,
	input  logic [cftd_pkg::TICK_W-1:0]     tick_count,
	input  logic [cftd_pkg::WORD_IDX_W-1:0] read_word,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  logic [cftd_pkg::DATA_W-1:0]     read_data,
	output int                              mismatches,
	output int                              reads_pending
);
	import cftd_pkg::*;

	localparam int IMAGE_WORDS     = 16;
	localparam int SSM_WORD0       = 4;
	localparam int PSM_WORD0       = 12;
	localparam int PSM_ISO_BIT     = 50;
	localparam int PSM_FREQ_LSB    = 51;
	localparam int ID_REGS         = 6;
	localparam int MISMATCH_PRINTS = 100;

	logic [ID_W-1:0]      id_reg [ID_REGS];
	logic [7:0]           switch_bytes [12];
	logic [7:0]           flash_bytes [12];
	logic [PERIOD_W-1:0]  flash_period;
	logic [SEQ_W-1:0]     seq_num;
	logic                 cpu_alive;
	logic [SSM_REC_W-1:0] ssm_rec [SSM_IDS];
	logic [PSM_REC_W-1:0] psm_rec [PSM_IDS];
	logic [DATA_W-1:0]    snapshot [IMAGE_WORDS];
	logic [DROP_W-1:0]    drop_cnt;
	logic [DATA_W-1:0]    words_due [$];
	logic [DATA_W-1:0]    want;
	logic [APB_DATA_W-1:0] want_reg;
	reg_idx_e             reg_sel;

	task automatic clear_state();
		for (int i = 0; i < ID_REGS; i++) id_reg[i] = '0;
		for (int i = 0; i < 12; i++) begin
			switch_bytes[i] = '0;
			flash_bytes[i] = '0;
		end
		flash_period = '0;
		seq_num = '0;
		cpu_alive = 1'b0;
		for (int i = 0; i < SSM_IDS; i++) ssm_rec[i] = '0;
		for (int i = 0; i < PSM_IDS; i++) psm_rec[i] = '0;
		for (int i = 0; i < IMAGE_WORDS; i++) snapshot[i] = '0;
		drop_cnt = '0;
		words_due.delete();
	endtask

	task automatic decode_frame(input logic [ID_W-1:0] id, input logic [CNT_W-1:0] cnt,
			input logic [PAYLOAD_W-1:0] pl);
		logic [7:0] b [8];
		int len;
		int idv;
		int ssm_base;
		int psm_base;
		int k;
		logic [SSM_REC_W-1:0] srec;
		logic [PSM_REC_W-1:0] prec;
		for (int i = 0; i < 8; i++) b[i] = pl[8*i +: 8];
		len = (cnt > LEN_MAX) ? int'(LEN_MAX) : int'(cnt);
		idv = id;
		ssm_base = id_reg[REG_SSM_BASE];
		psm_base = id_reg[REG_PSM_BASE];
		if (id == id_reg[REG_SWITCH_LOW]) begin
			if (len >= LEN_COPY)
				for (int i = 0; i < COPY_BYTES && i < len; i++) switch_bytes[i] = b[i];
		end else if (id == id_reg[REG_SWITCH_HIGH]) begin
			if (len >= LEN_COPY) begin
				for (int i = 0; i < COPY_BYTES && i < len; i++)
					switch_bytes[COPY_BYTES + i] = b[i];
				seq_num = seq_num + 1'b1;
				cpu_alive = 1'b1;
			end
		end else if (id == id_reg[REG_FLASH_LOW]) begin
			if (len >= LEN_COPY)
				for (int i = 0; i < COPY_BYTES && i < len; i++) flash_bytes[i] = b[i];
		end else if (id == id_reg[REG_FLASH_HIGH]) begin
			if (len >= LEN_FLASH_HIGH) begin
				for (int i = 0; i < COPY_BYTES && i < len; i++)
					flash_bytes[COPY_BYTES + i] = b[i];
				if (len >= LEN_PERIOD) flash_period = b[5][PERIOD_W-1:0];
			end
		end else if (idv >= ssm_base && idv - ssm_base < SSM_IDS) begin
			k = idv - ssm_base;
			if (k < SSM_MODULES && len >= LEN_SSM) begin
				srec = ssm_rec[k];
				srec[11:0] = {b[1][3:0], b[0]};
				for (int g = 0; g < CURRENT_GROUPS && g < MAX_GROUPS; g++)
					srec[SSM_CUR_LSB + ADC_W*g +: ADC_W] = {b[6][2*g +: 2], b[2+g]};
				srec[SSM_ALIVE_BIT] = 1'b1;
				ssm_rec[k] = srec;
			end
		end else if (idv >= psm_base && idv - psm_base < PSM_IDS) begin
			k = idv - psm_base;
			if (k < PSM_MODULES && len >= LEN_PSM) begin
				prec = '0;
				for (int a = 0; a < PSM_ADCS; a++)
					prec[ADC_W*a +: ADC_W] = {b[5][2*a +: 2], b[a]};
				prec[ADC_W*PSM_ADCS +: ADC_W] = {b[6][1:0], b[4]};
				prec[PSM_ISO_BIT] = b[6][2];
				prec[PSM_FREQ_LSB +: 8] = b[7];
				prec[PSM_ALIVE_BIT] = 1'b1;
				psm_rec[k] = prec;
			end
		end else if (drop_cnt != DROP_MAX) begin
			drop_cnt = drop_cnt + 1'b1;
		end
	endtask

	task automatic take_snapshot(input logic [TICK_W-1:0] ticks);
		for (int i = 0; i < IMAGE_WORDS; i++) snapshot[i] = '0;
		snapshot[0] = {9'd0, flash_period, cpu_alive, seq_num, ticks};
		for (int i = 0; i < 8; i++) begin
			snapshot[1][8*i +: 8] = switch_bytes[i];
			snapshot[3][8*i +: 8] = flash_bytes[i];
		end
		for (int i = 0; i < 4; i++) begin
			snapshot[2][8*i +: 8] = switch_bytes[8+i];
			snapshot[2][32 + 8*i +: 8] = flash_bytes[8+i];
		end
		for (int i = 0; i < SSM_MODULES && i < SSM_IDS; i++)
			snapshot[SSM_WORD0 + i] = DATA_W'(ssm_rec[i]);
		for (int i = 0; i < PSM_MODULES && i < PSM_IDS; i++)
			snapshot[PSM_WORD0 + i] = DATA_W'(psm_rec[i]);
		cpu_alive = 1'b0;
		for (int i = 0; i < SSM_MODULES && i < SSM_IDS; i++) ssm_rec[i][SSM_ALIVE_BIT] = 1'b0;
		for (int i = 0; i < PSM_MODULES && i < PSM_IDS; i++) psm_rec[i][PSM_ALIVE_BIT] = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			mismatches = 0;
			reads_pending = 0;
		end else begin
			if (psel && penable && pready) begin
				reg_sel = reg_idx_e'(paddr[4:2]);
				if (pwrite) begin
					if (reg_sel < REG_DROP_COUNT) id_reg[reg_sel] = pwdata[ID_W-1:0];
				end else if (reg_sel <= REG_DROP_COUNT) begin
					want_reg = (reg_sel == REG_DROP_COUNT) ? APB_DATA_W'(drop_cnt)
						: APB_DATA_W'(id_reg[reg_sel]);
					if (prdata !== want_reg) begin
						if (mismatches < MISMATCH_PRINTS)
							$display("%0t: register %s expected %h, got %h",
								$time, reg_sel.name(), want_reg, prdata);
						mismatches++;
					end
				end
			end
			if (result_valid && !result_stall) begin
				if (words_due.size() == 0) begin
					if (mismatches < MISMATCH_PRINTS)
						$display("%0t: read_data expected none, got %h", $time, read_data);
					mismatches++;
				end else begin
					want = words_due.pop_front();
					if (read_data !== want) begin
						if (mismatches < MISMATCH_PRINTS)
							$display("%0t: read_data expected %h, got %h",
								$time, want, read_data);
						mismatches++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				case (op)
					OP_FRAME:  if (standard_id) decode_frame(frame_id, byte_count, payload);
					OP_COMMIT: take_snapshot(tick_count);
					OP_READ:   words_due.push_back(snapshot[read_word]);
					default:   ;
				endcase
			end
			reads_pending = words_due.size();
		end
	end

endmodule

### tb/tb_can_frame_telemetry_decoder.sv
`timescale 1ns / 100ps

module tb_can_frame_telemetry_decoder;
	import cftd_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 10;
	localparam int DRAIN_CYCLES  = 4;
	localparam int QUIET_LIMIT   = 1000;
	localparam int PHASE_ITEMS   = 195;
	localparam int ID_REGS       = 6;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [PAYLOAD_W-1:0] PAT_ONES = '1;
	localparam logic [PAYLOAD_W-1:0] PAT_A    = 64'h0123_4567_89AB_CDEF;
	localparam logic [PAYLOAD_W-1:0] PAT_B    = 64'hA5C3_3C5A_F00F_0FF0;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  item_valid;
	logic                  item_stall;
	logic [1:0]            op;
	logic                  standard_id;
	logic [ID_W-1:0]       frame_id;
	logic [CNT_W-1:0]      byte_count;
	logic [PAYLOAD_W-1:0]  payload;
	logic [TICK_W-1:0]     tick_count;
	logic [WORD_IDX_W-1:0] read_word;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [DATA_W-1:0]     read_data;
	int                    mismatches;
	int                    reads_pending;

	logic [ID_W-1:0] cur_ids [ID_REGS];
	logic            calm;
	int unsigned     stall_left = 0;
	int unsigned     stall_draw;
	int              quiet = 0;
	int              n_frames = 0;
	int              n_commits = 0;
	int              n_reads = 0;
	int              n_other = 0;
	int              n_settings = 0;

	can_frame_telemetry_decoder dut (.*);

	can_frame_telemetry_decoder_checker image_check (.*);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else if (result_valid && !result_stall) begin
			stall_draw = calm ? 0 : $urandom_range(0, 3);
			stall_left <= stall_draw;
			result_stall <= (stall_draw != 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_stall <= (stall_left > 1);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic apb_access(input logic wr, input reg_idx_e idx, input logic [APB_DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_ids(input logic [ID_W-1:0] swl, input logic [ID_W-1:0] swh,
			input logic [ID_W-1:0] fll, input logic [ID_W-1:0] flh,
			input logic [ID_W-1:0] ssm, input logic [ID_W-1:0] psm);
		cur_ids[REG_SWITCH_LOW] = swl;
		cur_ids[REG_SWITCH_HIGH] = swh;
		cur_ids[REG_FLASH_LOW] = fll;
		cur_ids[REG_FLASH_HIGH] = flh;
		cur_ids[REG_SSM_BASE] = ssm;
		cur_ids[REG_PSM_BASE] = psm;
		for (int i = 0; i < ID_REGS; i++)
			apb_access(1'b1, reg_idx_e'(i), APB_DATA_W'(cur_ids[i]));
		n_settings++;
	endtask

	task automatic check_regs();
		for (int i = 0; i <= REG_DROP_COUNT; i++) apb_access(1'b0, reg_idx_e'(i), '0);
	endtask

	task automatic send_item(input logic [1:0] o, input logic s, input logic [ID_W-1:0] id,
			input logic [CNT_W-1:0] cnt, input logic [PAYLOAD_W-1:0] pl,
			input logic [TICK_W-1:0] tk, input logic [WORD_IDX_W-1:0] w);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= o;
		standard_id <= s;
		frame_id <= id;
		byte_count <= cnt;
		payload <= pl;
		tick_count <= tk;
		read_word <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		case (o)
			OP_FRAME:  n_frames++;
			OP_COMMIT: n_commits++;
			OP_READ:   n_reads++;
			default:   n_other++;
		endcase
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (reads_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_directed();
		send_item(OP_READ, 1'b1, '0, '0, '0, '0, '0);
		send_item(OP_FRAME, 1'b1, cur_ids[REG_SWITCH_LOW], 4'd8, PAT_ONES, '0, '0);
		send_item(OP_FRAME, 1'b1, cur_ids[REG_SWITCH_HIGH], 4'd4, PAT_A, '0, '0);
		send_item(OP_FRAME, 1'b1, cur_ids[REG_SWITCH_HIGH], 4'd3, PAT_ONES, '0, '0);
		send_item(OP_FRAME, 1'b1, cur_ids[REG_FLASH_LOW], 4'd6, PAT_B, '0, '0);
		send_item(OP_FRAME, 1'b1, cur_ids[REG_FLASH_HIGH], 4'd5, PAT_A, '0, '0);
		send_item(OP_FRAME, 1'b1, cur_ids[REG_FLASH_HIGH], 4'd6, PAT_ONES, '0, '0);
		send_item(OP_FRAME, 1'b1, cur_ids[REG_FLASH_HIGH], 4'd4, '0, '0, '0);
		send_item(OP_FRAME, 1'b1, cur_ids[REG_SSM_BASE], 4'd7, PAT_ONES, '0, '0);
		send_item(OP_FRAME, 1'b1, cur_ids[REG_SSM_BASE] + 11'd7, 4'd15, PAT_B, '0, '0);
		send_item(OP_FRAME, 1'b1, cur_ids[REG_SSM_BASE] + 11'd3, 4'd6, PAT_A, '0, '0);
		send_item(OP_FRAME, 1'b1, cur_ids[REG_PSM_BASE], 4'd8, PAT_A, '0, '0);
		send_item(OP_FRAME, 1'b1, cur_ids[REG_PSM_BASE] + 11'd1, 4'd7, PAT_ONES, '0, '0);
		send_item(OP_FRAME, 1'b1, cur_ids[REG_PSM_BASE] + 11'd1, 4'd9, PAT_ONES, '0, '0);
		send_item(OP_FRAME, 1'b0, cur_ids[REG_SWITCH_HIGH], 4'd8, '0, '0, '0);
		send_item(OP_FRAME, 1'b1, 11'd0, 4'd8, PAT_B, '0, '0);
		send_item(OP_FRAME, 1'b1, 11'd2047, 4'd0, '0, '0, '0);
		send_item(OP_UNUSED, 1'b1, cur_ids[REG_SWITCH_LOW], 4'd8, '0, '1, '1);
		send_item(OP_COMMIT, 1'b1, '0, '0, '0, '1, '0);
		for (int w = 0; w < 16; w++)
			if (w < 5 || w > 10) send_item(OP_READ, 1'b1, '0, '0, '0, '0, WORD_IDX_W'(w));
		send_item(OP_COMMIT, 1'b1, '0, '0, '0, '0, '0);
		send_item(OP_READ, 1'b1, '0, '0, '0, '0, '0);
	endtask

	task automatic random_item(output logic counted);
		int unsigned r;
		logic [1:0] o;
		logic s;
		logic [ID_W-1:0] id;
		logic [CNT_W-1:0] cnt;
		r = $urandom_range(0, 99);
		if (r < 68) o = OP_FRAME;
		else if (r < 78) o = OP_COMMIT;
		else if (r < 95) o = OP_READ;
		else o = OP_UNUSED;
		s = ($urandom_range(0, 9) != 0);
		r = $urandom_range(0, 15);
		if (r < 4) id = cur_ids[r];
		else if (r < 10) id = cur_ids[REG_SSM_BASE] + ID_W'($urandom_range(0, 9));
		else if (r < 13) id = cur_ids[REG_PSM_BASE] + ID_W'($urandom_range(0, 2));
		else id = ID_W'($urandom_range(0, 2047));
		if ($urandom_range(0, 9) < 7) cnt = CNT_W'($urandom_range(4, 8));
		else cnt = CNT_W'($urandom_range(0, 15));
		send_item(o, s, id, cnt, {$urandom, $urandom}, $urandom,
			WORD_IDX_W'($urandom_range(0, 15)));
		counted = !(o == OP_UNUSED || (o == OP_FRAME && !s));
	endtask

	task automatic run_random(input int n);
		int done;
		int k;
		logic counted;
		done = 0;
		k = 0;
		while (done < n) begin
			calm = ((k / 40) % 5 == 4);
			random_item(counted);
			if (counted) done++;
			k++;
		end
		calm = 1'b0;
		wait_idle();
		check_regs();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		op = OP_FRAME;
		standard_id = 1'b0;
		frame_id = '0;
		byte_count = '0;
		payload = '0;
		tick_count = '0;
		read_word = '0;
		calm = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_regs();

		set_ids(11'h100, 11'h101, 11'h102, 11'h103, 11'h110, 11'h118);
		run_directed();
		run_random(PHASE_ITEMS);

		set_ids(11'd2047, 11'd0, 11'd1024, 11'd1025, 11'd2047, 11'd2046);
		run_random(PHASE_ITEMS);

		set_ids(11'd5, 11'd6, 11'd7, 11'd8, 11'd0, 11'd2047);
		run_random(PHASE_ITEMS);

		set_ids(ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
			ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
			ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)));
		run_random(PHASE_ITEMS);

		set_ids(ID_W'($urandom_range(0, 63)), ID_W'($urandom_range(0, 63)),
			ID_W'($urandom_range(0, 63)), ID_W'($urandom_range(0, 63)),
			ID_W'($urandom_range(0, 63)), ID_W'($urandom_range(0, 63)));
		run_random(PHASE_ITEMS);

		set_ids('0, '0, '0, '0, '0, '0);
		run_random(PHASE_ITEMS);

		$display("Ran %0d frames, %0d commits, %0d reads, %0d unused-op items, %0d id settings",
			n_frames, n_commits, n_reads, n_other, n_settings);
		$display("Covered overlapping and edge ids, short and long frames, extended ids; registers read back after every setting");
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
